// ===== design/sch_pkg.sv =====
// Shared types, constants and helper functions for the sector coordinate seed hash.
// Used by sch_hash_front, sch_sort_net and sector_coordinate_seed_hash_core.
// Depends on nothing.
`default_nettype none

package sch_pkg;

	// Odd multipliers of the hash, full 32-bit values.
	localparam logic [31:0] MUL_A = 32'd4016331601;
	localparam logic [31:0] MUL_B = 32'd3871808917;
	localparam logic [31:0] MUL_C = 32'd3316090507;
	localparam logic [31:0] MUL_D = 32'd2421215411;
	localparam logic [31:0] MUL_E = 32'd1565016097;
	localparam logic [31:0] MUL_F = 32'd3345900949;

	// Width of one hash piece and the number of pieces that are sorted.
	localparam int unsigned PIECE_W     = 16;
	localparam int unsigned PIECE_COUNT = 8;
	localparam int unsigned PROD_COUNT  = 12;
	localparam int unsigned MIX_COUNT   = 6;

	// Configuration register map, by register index.
	localparam int unsigned ADDR_W        = 3;
	localparam logic        REG_WORLD_SEED = 1'b0;

	typedef logic [PIECE_W-1:0] piece_t;
	typedef piece_t piece_vec_t [PIECE_COUNT];

	// Low half of a product; only the low 16 bits of each operand reach it.
	function automatic piece_t mul_lo(input piece_t a, input piece_t b);
		logic [2*PIECE_W-1:0] full;
		full = a * b;
		return full[PIECE_W-1:0];
	endfunction

	// Offset term of a single-coordinate word: (k + w) xor w.
	function automatic piece_t mix_off(input piece_t k, input piece_t w);
		piece_t s;
		s = k + w;
		return s ^ w;
	endfunction

endpackage

`default_nettype wire

// ===== design/sch_hash_front.sv =====
// Front end of the seed hash: two pipeline stages that form the eight 16-bit pieces.
// Stage one holds the products and seed terms, stage two the mixed pieces.
// Depends on sch_pkg.
`default_nettype none

module sch_hash_front (
	input  logic               clk,
	input  logic               arst_n,
	input  logic [31:0]        seed,
	input  logic               in_valid,
	output logic               in_ready,
	input  sch_pkg::piece_t    x,
	input  sch_pkg::piece_t    y,
	input  sch_pkg::piece_t    z,
	output logic               out_valid,
	input  logic               out_ready,
	output sch_pkg::piece_vec_t pieces
);
	import sch_pkg::*;

	// Every word is reduced to its low 16 bits at the end, and the low bits of
	// sums, products and xors depend only on the low bits of their operands,
	// so the whole hash is carried out on 16-bit values.
	piece_t w;
	piece_t ka, kb, kc, kd, ke, kf;

	piece_t prod_c [PROD_COUNT];
	piece_t off_c [MIX_COUNT];
	piece_t k6_c, k7_c;

	logic   valid_s1;
	piece_t prod_s1 [PROD_COUNT];
	piece_t off_s1 [MIX_COUNT];
	piece_t k6_s1, k7_s1, w_s1;

	logic       valid_s2;
	piece_vec_t pieces_s2;
	piece_vec_t pieces_c;
	piece_t     sum6_c, sum7_c;

	logic ready_s1, ready_s2;

	assign w  = seed[PIECE_W-1:0];
	assign ka = MUL_A[PIECE_W-1:0];
	assign kb = MUL_B[PIECE_W-1:0];
	assign kc = MUL_C[PIECE_W-1:0];
	assign kd = MUL_D[PIECE_W-1:0];
	assign ke = MUL_E[PIECE_W-1:0];
	assign kf = MUL_F[PIECE_W-1:0];

	// A stage takes a new beat when it is empty or its contents move on.
	assign ready_s2  = !valid_s2 || out_ready;
	assign ready_s1  = !valid_s1 || ready_s2;
	assign in_ready  = ready_s1;
	assign out_valid = valid_s2;
	assign pieces    = pieces_s2;

	// Stage one logic: the twelve products and the seed-only terms.
	always_comb begin
		prod_c[0]  = mul_lo(x, ka);
		prod_c[1]  = mul_lo(x, kc);
		prod_c[2]  = mul_lo(y, kd);
		prod_c[3]  = mul_lo(y, ke);
		prod_c[4]  = mul_lo(z, kf);
		prod_c[5]  = mul_lo(z, kb);
		prod_c[6]  = mul_lo(x, kb);
		prod_c[7]  = mul_lo(y, kf);
		prod_c[8]  = mul_lo(z, ke);
		prod_c[9]  = mul_lo(x, kd);
		prod_c[10] = mul_lo(y, kc);
		prod_c[11] = mul_lo(z, ka);
		off_c[0]   = mix_off(kb, w);
		off_c[1]   = mix_off(ka, w);
		off_c[2]   = mix_off(kc, w);
		off_c[3]   = mix_off(kd, w);
		off_c[4]   = mix_off(ke, w);
		off_c[5]   = mix_off(kf, w);
		k6_c       = (ke ^ w) + (kb ^ w) + (kf ^ w);
		k7_c       = (kc ^ w) + (ka ^ w) + (kd ^ w);
	end

	// Stage one valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (ready_s1) begin
			valid_s1 <= in_valid;
		end
	end

	// Stage one payload.
	always_ff @(posedge clk) begin
		if (ready_s1 && in_valid) begin
			prod_s1 <= prod_c;
			off_s1  <= off_c;
			k6_s1   <= k6_c;
			k7_s1   <= k7_c;
			w_s1    <= w;
		end
	end

	// Stage two logic: add the offsets and fold in the seed by xor.
	always_comb begin
		sum6_c = prod_s1[6] + prod_s1[7] + prod_s1[8] + k6_s1;
		sum7_c = prod_s1[9] + prod_s1[10] + prod_s1[11] + k7_s1;
		for (int i = 0; i < MIX_COUNT; i++) begin
			pieces_c[i] = (prod_s1[i] + off_s1[i]) ^ w_s1;
		end
		pieces_c[6] = sum6_c ^ w_s1;
		pieces_c[7] = sum7_c ^ w_s1;
	end

	// Stage two valid bit.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (ready_s2) begin
			valid_s2 <= valid_s1;
		end
	end

	// Stage two payload.
	always_ff @(posedge clk) begin
		if (ready_s2 && valid_s1) begin
			pieces_s2 <= pieces_c;
		end
	end

endmodule

`default_nettype wire

// ===== design/sch_sort_net.sv =====
// Eight-input odd-even merge sorting network, two comparator layers per stage,
// with the nibble packing in its last stage. Depends on sch_pkg.
`default_nettype none

module sch_sort_net (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                in_valid,
	output logic                in_ready,
	input  sch_pkg::piece_vec_t pieces,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [31:0]         packed_seed
);
	import sch_pkg::*;

	logic       valid_s3, valid_s4, valid_s5;
	piece_vec_t sort_s3, sort_s4;
	logic [31:0] packed_s5;
	piece_vec_t l1_c, l2_c, l3_c, l4_c, l5_c, l6_c;
	logic       ready_s3, ready_s4, ready_s5;

	// Compare and exchange: the smaller value ends at the lower position.
	function automatic piece_vec_t cx(input piece_vec_t v, input logic [2:0] a,
			input logic [2:0] b);
		piece_vec_t r;
		r = v;
		if (v[a] > v[b]) begin
			r[a] = v[b];
			r[b] = v[a];
		end
		return r;
	endfunction

	assign ready_s5    = !valid_s5 || out_ready;
	assign ready_s4    = !valid_s4 || ready_s5;
	assign ready_s3    = !valid_s3 || ready_s4;
	assign in_ready    = ready_s3;
	assign out_valid   = valid_s5;
	assign packed_seed = packed_s5;

	// Layers one and two: sort pairs, then begin merging pairs into fours.
	always_comb begin
		l1_c = cx(pieces, 3'd0, 3'd1);
		l1_c = cx(l1_c, 3'd2, 3'd3);
		l1_c = cx(l1_c, 3'd4, 3'd5);
		l1_c = cx(l1_c, 3'd6, 3'd7);
		l2_c = cx(l1_c, 3'd0, 3'd2);
		l2_c = cx(l2_c, 3'd1, 3'd3);
		l2_c = cx(l2_c, 3'd4, 3'd6);
		l2_c = cx(l2_c, 3'd5, 3'd7);
	end

	// Layers three and four: finish the fours, start the final merge.
	always_comb begin
		l3_c = cx(sort_s3, 3'd1, 3'd2);
		l3_c = cx(l3_c, 3'd5, 3'd6);
		l4_c = cx(l3_c, 3'd0, 3'd4);
		l4_c = cx(l4_c, 3'd1, 3'd5);
		l4_c = cx(l4_c, 3'd2, 3'd6);
		l4_c = cx(l4_c, 3'd3, 3'd7);
	end

	// Layers five and six: finish the merge of the two fours.
	always_comb begin
		l5_c = cx(sort_s4, 3'd2, 3'd4);
		l5_c = cx(l5_c, 3'd3, 3'd5);
		l6_c = cx(l5_c, 3'd1, 3'd2);
		l6_c = cx(l6_c, 3'd3, 3'd4);
		l6_c = cx(l6_c, 3'd5, 3'd6);
	end

	// Valid bits of the three sorting stages.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s3 <= 1'b0;
			valid_s4 <= 1'b0;
			valid_s5 <= 1'b0;
		end else begin
			if (ready_s3) begin
				valid_s3 <= in_valid;
			end
			if (ready_s4) begin
				valid_s4 <= valid_s3;
			end
			if (ready_s5) begin
				valid_s5 <= valid_s4;
			end
		end
	end

	// Stage payloads; the last one keeps only the packed low nibbles,
	// smallest piece in the top nibble.
	always_ff @(posedge clk) begin
		if (ready_s3 && in_valid) begin
			sort_s3 <= l2_c;
		end
		if (ready_s4 && valid_s3) begin
			sort_s4 <= l4_c;
		end
		if (ready_s5 && valid_s4) begin
			packed_s5 <= {l6_c[0][3:0], l6_c[1][3:0], l6_c[2][3:0], l6_c[3][3:0],
				l6_c[4][3:0], l6_c[5][3:0], l6_c[6][3:0], l6_c[7][3:0]};
		end
	end

endmodule

`default_nettype wire

// ===== design/sector_coordinate_seed_hash_core.sv =====
// Top level of the sector coordinate seed hash: configuration port and the
// five-stage hash pipeline. Depends on sch_pkg, sch_hash_front and sch_sort_net.
//
//   Channel  Handshake                 Payload
//   config   psel/penable/pready       paddr, pwrite, pwdata, prdata (world_seed)
//   input    in_valid/in_ready         coord_x, coord_y, coord_z
//   output   out_valid/out_ready       sector_seed
//
// One beat enters per cycle while the pipeline is not stalled. Its result passes
// through the five register stages in order: products, mixing and three stages
// of the sorting network, the last of which holds the packed result.
// Reset clears the world seed and every stage valid bit.
// Each stage holds its beat while the next one is full and stalled, so empty
// stages keep filling while the output waits.
`default_nettype none

module sector_coordinate_seed_hash_core (
	input  logic                       clk,
	input  logic                       arst_n,
	input  logic                       psel,
	input  logic                       penable,
	input  logic                       pwrite,
	input  logic [sch_pkg::ADDR_W-1:0] paddr,
	input  logic [31:0]                pwdata,
	output logic [31:0]                prdata,
	output logic                       pready,
	input  logic                       in_valid,
	output logic                       in_ready,
	input  logic signed [31:0]         coord_x,
	input  logic signed [31:0]         coord_y,
	input  logic signed [31:0]         coord_z,
	output logic                       out_valid,
	input  logic                       out_ready,
	output logic [31:0]                sector_seed
);
	import sch_pkg::*;

	logic [31:0] world_seed_q;
	logic        reg_index;
	logic        front_valid, front_ready;
	piece_vec_t  front_pieces;

	// Register index is the word address; byte offset bits are ignored.
	assign reg_index = paddr[ADDR_W-1];
	assign pready    = 1'b1;

	// Configuration register write.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			world_seed_q <= '0;
		end else if (psel && penable && pwrite && reg_index == REG_WORLD_SEED) begin
			world_seed_q <= pwdata;
		end
	end

	// Read back; unmapped addresses read as zero.
	always_comb begin
		prdata = '0;
		if (reg_index == REG_WORLD_SEED) begin
			prdata = world_seed_q;
		end
	end

	// Product and mixing stages.
	sch_hash_front u_front (
		.clk       (clk),
		.arst_n    (arst_n),
		.seed      (world_seed_q),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.x         (coord_x[PIECE_W-1:0]),
		.y         (coord_y[PIECE_W-1:0]),
		.z         (coord_z[PIECE_W-1:0]),
		.out_valid (front_valid),
		.out_ready (front_ready),
		.pieces    (front_pieces)
	);

	// Sorting stages and result register.
	sch_sort_net u_sort (
		.clk         (clk),
		.arst_n      (arst_n),
		.in_valid    (front_valid),
		.in_ready    (front_ready),
		.pieces      (front_pieces),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.packed_seed (sector_seed)
	);

endmodule

`default_nettype wire
